/* rtl/core/nae_pkg.sv */
// Package for the NNUE accumulator evaluator: action codes and fixed widths.
// No dependencies; used by the core top level.
package nae_pkg;
    typedef enum logic [2:0] {
        ACT_LOAD_WEIGHT = 3'd0,
        ACT_LOAD_BIAS   = 3'd1,
        ACT_LOAD_OUTW   = 3'd2,
        ACT_RESET_BIAS  = 3'd3,
        ACT_ADD         = 3'd4,
        ACT_REMOVE      = 3'd5,
        ACT_EVALUATE    = 3'd6
    } t_action;

    localparam int WORD_W  = 16;
    localparam int SCORE_W = 26;
    localparam int SUM_W   = 32;
    localparam logic [6:0] CLIP_MAX = 7'd127;
endpackage

/* rtl/core/nae_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module nae_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        o_rdata <= mem[i_raddr];
    end
endmodule

/* rtl/core/nnue_accumulator_evaluator_core.sv */
// NNUE accumulator evaluator core: weight, bias, output-weight and accumulator RAMs.
// A load writes its RAM when accepted and does not stall the input. Reset-to-bias,
// add and remove walk all HIDDEN entries one per cycle, set by the single read port of
// each RAM; the input stalls until the walk has drained. Evaluate presents its score
// after the walk and product pipeline; the next request is taken after the score leaves.
// Sync active-low reset clears control and the score bias; RAMs undefined until written.
module nnue_accumulator_evaluator_core #(
    parameter int INPUTS     = 768,
    parameter int HIDDEN     = 256,
    parameter int SCALE_BITS = 6
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [2:0]                       i_action,
    input  logic [9:0]                       i_feature_index,
    input  logic [7:0]                       i_hidden_index,
    input  logic signed [15:0]               i_load_value,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic signed [nae_pkg::SCORE_W-1:0] o_score,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic signed [31:0]               i_cfg_data
);
    localparam int HW = $clog2(HIDDEN);
    localparam int FW = $clog2(INPUTS) > 0 ? $clog2(INPUTS) : 1;
    localparam int WD = INPUTS * HIDDEN;
    localparam int WW = $clog2(WD);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_WALK = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_OUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    nae_pkg::t_action r_op;
    logic [FW-1:0] r_feat;
    logic [HW:0]   r_cnt;
    // Pipeline: stage 1 = data back and written, stage 2 = product accumulated.
    logic          r_v1, r_v2;
    logic [HW-1:0] r_a1;
    logic [31:0]   r_bias;
    logic [31:0]   r_sum;
    logic [31:0]   r_prod;
    logic          r_pv;
    logic signed [nae_pkg::SCORE_W-1:0] r_score;
    logic          r_ovalid;

    nae_pkg::t_action act;
    assign act = nae_pkg::t_action'(i_action);

    wire accept = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;

    wire hid_ok  = {24'd0, i_hidden_index} < 32'(HIDDEN);
    wire feat_ok = {22'd0, i_feature_index} < 32'(INPUTS);

    // RAM ports
    logic          w_we, b_we, o_we, a_we;
    logic [WW-1:0] w_waddr, w_raddr;
    logic [HW-1:0] h_waddr;
    logic [15:0]   w_rd, b_rd, o_rd, a_rd, a_wd;
    logic [HW-1:0] rd_addr;

    assign rd_addr = r_cnt[HW-1:0];
    assign h_waddr = i_hidden_index[HW-1:0];
    assign w_we = accept && act == nae_pkg::ACT_LOAD_WEIGHT && feat_ok && hid_ok;
    assign b_we = accept && act == nae_pkg::ACT_LOAD_BIAS && hid_ok;
    assign o_we = accept && act == nae_pkg::ACT_LOAD_OUTW && hid_ok;
    assign w_waddr = WW'(i_feature_index * HIDDEN + i_hidden_index);
    assign w_raddr = WW'(r_feat * HIDDEN + rd_addr);

    nae_ram #(.WIDTH(16), .DEPTH(WD)) u_wram (
        .i_clk, .i_we(w_we), .i_waddr(w_waddr), .i_wdata(i_load_value),
        .i_raddr(w_raddr), .o_rdata(w_rd));
    nae_ram #(.WIDTH(16), .DEPTH(HIDDEN)) u_bram (
        .i_clk, .i_we(b_we), .i_waddr(h_waddr), .i_wdata(i_load_value),
        .i_raddr(rd_addr), .o_rdata(b_rd));
    nae_ram #(.WIDTH(16), .DEPTH(HIDDEN)) u_oram (
        .i_clk, .i_we(o_we), .i_waddr(h_waddr), .i_wdata(i_load_value),
        .i_raddr(rd_addr), .o_rdata(o_rd));
    // Each entry is read once and, except on evaluate, written back the next cycle; addresses never overlap.
    nae_ram #(.WIDTH(16), .DEPTH(HIDDEN)) u_aram (
        .i_clk, .i_we(a_we), .i_waddr(r_a1), .i_wdata(a_wd),
        .i_raddr(rd_addr), .o_rdata(a_rd));

    always_comb begin
        a_we = 1'b0;
        a_wd = a_rd;
        case (r_op)
            nae_pkg::ACT_RESET_BIAS: begin a_we = r_v1; a_wd = b_rd; end
            nae_pkg::ACT_ADD:        begin a_we = r_v1; a_wd = a_rd + w_rd; end
            nae_pkg::ACT_REMOVE:     begin a_we = r_v1; a_wd = a_rd - w_rd; end
            default: ;
        endcase
    end

    // Clipped value times output weight, registered before accumulation.
    logic [6:0]  clip;
    logic signed [31:0] prod;
    always_comb begin
        if (a_rd[15]) clip = 7'd0;
        else if (a_rd > 16'(nae_pkg::CLIP_MAX)) clip = nae_pkg::CLIP_MAX;
        else clip = a_rd[6:0];
        prod = $signed({1'b0, clip}) * $signed(o_rd);
    end

    wire walk_done = (r_cnt == (HW+1)'(HIDDEN - 1));

    logic [31:0] mag;
    logic [31:0] scaled;
    always_comb begin
        mag = r_sum[31] ? (32'd0 - r_sum) : r_sum;
        mag = mag >> SCALE_BITS;
        scaled = r_sum[31] ? (32'd0 - mag) : mag;
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (act == nae_pkg::ACT_RESET_BIAS || act == nae_pkg::ACT_EVALUATE
                    || ((act == nae_pkg::ACT_ADD || act == nae_pkg::ACT_REMOVE) && feat_ok)))
                    n_state = ST_WALK;
            end
            ST_WALK:  if (walk_done) n_state = ST_DRAIN;
            ST_DRAIN: if (!r_v1 && !r_v2 && !r_pv)
                          n_state = (r_op == nae_pkg::ACT_EVALUATE) ? ST_OUT : ST_IDLE;
            ST_OUT:   if (!r_ovalid) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_op     <= nae_pkg::ACT_LOAD_WEIGHT;
            r_v1     <= 1'b0;
            r_v2     <= 1'b0;
            r_pv     <= 1'b0;
            r_ovalid <= 1'b0;
            r_bias   <= 32'd0;
            r_cnt    <= '0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) r_bias <= i_cfg_data;
            if (r_state == ST_IDLE && accept) begin
                r_op   <= act;
                r_feat <= i_feature_index[FW-1:0];
                r_cnt  <= '0;
                r_sum  <= r_bias;
            end
            r_v1 <= (r_state == ST_WALK);
            r_a1 <= rd_addr;
            r_v2 <= r_v1 && (r_op == nae_pkg::ACT_EVALUATE);
            if (r_state == ST_WALK && !walk_done) r_cnt <= r_cnt + 1'b1;
            r_prod <= prod;
            r_pv   <= r_v2;
            if (r_v2) r_sum <= r_sum + r_prod;
            if (r_state == ST_DRAIN && n_state == ST_OUT) begin
                r_ovalid <= 1'b1;
                r_score  <= scaled[nae_pkg::SCORE_W-1:0];
            end else if (r_ovalid && !i_stall) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_valid = r_ovalid;
    assign o_score = r_score;
endmodule
